// ----- sv/rsi_pkg.sv -----
// Package for the ray/sphere intersection pipeline: fixed widths of every
// intermediate value and the item structure passed between pipeline sections.
// No dependencies.
`default_nettype none

package rsi_pkg;

   localparam int CW    = 32;            // coordinate width
   localparam int PW    = CW + 1;        // center - origin
   localparam int A_W   = 2 * CW;        // a = d.d, unsigned
   localparam int DP_W  = 2 * CW + 1;    // one d*p product, signed
   localparam int PP_W  = 2 * PW;        // one p*p product, signed
   localparam int RR_W  = 2 * (CW - 1);  // r*r, unsigned
   localparam int B_W   = 2 * CW + 1;    // b when non-negative
   localparam int BS_W  = 2 * CW + 2;    // b, signed
   localparam int K_W   = 2 * CW + 3;    // k = p.p - r*r, signed
   localparam int KU_W  = 2 * CW + 2;    // k when non-negative
   localparam int S_W   = 4 * CW + 2;    // discriminant on a hit
   localparam int D_W   = S_W + 2;       // discriminant working width
   localparam int R_W   = S_W / 2;       // integer square root
   localparam int T_W   = B_W + 1;       // b -/+ root
   localparam int HALF  = (T_W + 1) / 2; // low part of a split t operand
   localparam int TP_W  = HALF + CW;     // one partial product of t*|d|
   localparam int N_W   = T_W + CW;      // |t*d|
   localparam int Q_W   = CW + 1;        // quotient bits before saturation
   localparam int DIV_LAT = Q_W + 2;     // register stages in one divider
   localparam int IN_DW  = ((10 * CW - 1 + 7) / 8) * 8;
   localparam int OUT_DW = 6 * CW;

   typedef logic [2:0][CW-1:0] vec3_type;

   typedef struct packed {
      logic           hit;
      logic [A_W-1:0] a;
      logic [B_W-1:0] b;
      vec3_type       o;
      vec3_type       d;
   } ray_type;

endpackage

`default_nettype wire

// ----- sv/rsi_front.sv -----
// Front section: p = c - o, dot products a, b, k, discriminant and hit test.
// Six register stages. Depends on rsi_pkg.
`default_nettype none

module rsi_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  rsi_pkg::vec3_type        origin,
   input  rsi_pkg::vec3_type        dir,
   input  rsi_pkg::vec3_type        center,
   input  logic [rsi_pkg::CW-2:0]   radius,
   output logic                     out_valid,
   output rsi_pkg::ray_type         ray_out,
   output logic [rsi_pkg::S_W-1:0]  s_out
);
   import rsi_pkg::*;

   logic [5:0] v_ff;

   vec3_type              o1_ff, d1_ff, o2_ff, d2_ff, o3_ff, d3_ff, o4_ff, d4_ff, o5_ff, d5_ff;
   logic [2:0][PW-1:0]    p1_ff, p1_in;
   logic [CW-2:0]         r1_ff;
   logic [2:0][A_W-1:0]   dd2_ff, dd2_in;
   logic [2:0][DP_W-1:0]  dp2_ff, dp2_in;
   logic [2:0][PP_W-1:0]  pp2_ff, pp2_in;
   logic [RR_W-1:0]       rr2_ff, rr2_in;
   logic [A_W-1:0]        a3_ff, a3_in, a4_ff, a5_ff;
   logic [BS_W-1:0]       b3_ff, b3_in;
   logic [K_W-1:0]        k3_ff, k3_in;
   logic [B_W-1:0]        b4_ff, b5_ff;
   logic                  ok4_ff, ok4_in, ok5_ff;
   logic [CW:0]           bl;
   logic [B_W-CW-2:0]     bh;
   logic [CW-1:0]         al, ah, kl;
   logic [KU_W-CW-1:0]    kh;
   logic [2*(B_W-CW-1)-1:0] bhh_ff, bhh_in;
   logic [B_W-1:0]        bhl_ff, bhl_in;
   logic [2*(CW+1)-1:0]   bll_ff, bll_in;
   logic [KU_W-1:0]       akhh_ff, akhh_in, aklh_ff, aklh_in;
   logic [2*CW-1:0]       akhl_ff, akhl_in, akll_ff, akll_in;
   logic [D_W-1:0]        bsq5_ff, bsq5_in, ak5_ff, ak5_in;
   logic [D_W-1:0]        sd;
   logic                  hit6;
   ray_type               ray6_ff;
   logic [S_W-1:0]        s6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   // stage 1: p = c - o
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_in[i] = PW'($signed(center[i])) - PW'($signed(origin[i]));
      end
   end

   // stage 2: lane products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd2_in[i] = $signed(d1_ff[i]) * $signed(d1_ff[i]);
         dp2_in[i] = $signed(d1_ff[i]) * $signed(p1_ff[i]);
         pp2_in[i] = $signed(p1_ff[i]) * $signed(p1_ff[i]);
      end
      rr2_in = r1_ff * r1_ff;
   end

   // stage 3: sums
   always_comb begin
      a3_in = dd2_ff[0] + dd2_ff[1] + dd2_ff[2];
      b3_in = BS_W'($signed(dp2_ff[0])) + BS_W'($signed(dp2_ff[1]))
            + BS_W'($signed(dp2_ff[2]));
      k3_in = K_W'($signed(pp2_ff[0])) + K_W'($signed(pp2_ff[1]))
            + K_W'($signed(pp2_ff[2])) - K_W'(rr2_ff);
   end

   // stage 4: split b*b and a*k into narrow partial products
   always_comb begin
      bl = b3_ff[CW:0];
      bh = b3_ff[B_W-1:CW+1];
      al = a3_ff[CW-1:0];
      ah = a3_ff[A_W-1:CW];
      kl = k3_ff[CW-1:0];
      kh = k3_ff[KU_W-1:CW];
      ok4_in  = (a3_ff != '0) && !b3_ff[BS_W-1] && !k3_ff[K_W-1];
      bhh_in  = bh * bh;
      bhl_in  = bh * bl;
      bll_in  = bl * bl;
      akhh_in = ah * kh;
      akhl_in = ah * kl;
      aklh_in = al * kh;
      akll_in = al * kl;
   end

   // stage 5: recombine partial products
   always_comb begin
      bsq5_in = (D_W'(bhh_ff) << (2 * (CW + 1))) + (D_W'(bhl_ff) << (CW + 2))
              + D_W'(bll_ff);
      ak5_in  = (D_W'(akhh_ff) << (2 * CW)) + ((D_W'(akhl_ff) + D_W'(aklh_ff)) << CW)
              + D_W'(akll_ff);
   end

   // stage 6: discriminant and hit decision
   always_comb begin
      sd   = bsq5_ff - ak5_ff;
      hit6 = ok5_ff && !sd[D_W-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o1_ff   <= origin;
         d1_ff   <= dir;
         p1_ff   <= p1_in;
         r1_ff   <= radius;
         o2_ff   <= o1_ff;
         d2_ff   <= d1_ff;
         dd2_ff  <= dd2_in;
         dp2_ff  <= dp2_in;
         pp2_ff  <= pp2_in;
         rr2_ff  <= rr2_in;
         o3_ff   <= o2_ff;
         d3_ff   <= d2_ff;
         a3_ff   <= a3_in;
         b3_ff   <= b3_in;
         k3_ff   <= k3_in;
         o4_ff   <= o3_ff;
         d4_ff   <= d3_ff;
         a4_ff   <= a3_ff;
         b4_ff   <= b3_ff[B_W-1:0];
         ok4_ff  <= ok4_in;
         bhh_ff  <= bhh_in;
         bhl_ff  <= bhl_in;
         bll_ff  <= bll_in;
         akhh_ff <= akhh_in;
         akhl_ff <= akhl_in;
         aklh_ff <= aklh_in;
         akll_ff <= akll_in;
         o5_ff   <= o4_ff;
         d5_ff   <= d4_ff;
         a5_ff   <= a4_ff;
         b5_ff   <= b4_ff;
         ok5_ff  <= ok4_ff;
         bsq5_ff <= bsq5_in;
         ak5_ff  <= ak5_in;
         ray6_ff.hit <= hit6;
         ray6_ff.a   <= a5_ff;
         ray6_ff.b   <= b5_ff;
         ray6_ff.o   <= o5_ff;
         ray6_ff.d   <= d5_ff;
         s6_ff       <= hit6 ? sd[S_W-1:0] : '0;
      end
   end

   assign out_valid = v_ff[5];
   assign ray_out   = ray6_ff;
   assign s_out     = s6_ff;

endmodule

`default_nettype wire

// ----- sv/rsi_sqrt.sv -----
// Pipelined integer square root, one root bit per register stage, with the
// item's ray data carried alongside. Depends on rsi_pkg.
`default_nettype none

module rsi_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  rsi_pkg::ray_type         ray_in,
   input  logic [rsi_pkg::S_W-1:0]  s_in,
   output logic                     out_valid,
   output rsi_pkg::ray_type         ray_out,
   output logic [rsi_pkg::R_W-1:0]  q_out
);
   import rsi_pkg::*;

   logic [R_W-1:0] v_ff;
   logic [S_W-1:0] rem_ff  [R_W-1];
   logic [R_W-1:0] root_ff [R_W];
   ray_type        ray_ff  [R_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[R_W-2:0], in_valid};
      end
   end

   for (genvar j = 0; j < R_W; j++) begin : g_stage
      localparam int BIT = R_W - 1 - j;
      logic [S_W-1:0] rem_cur;
      logic [R_W-1:0] root_cur;
      ray_type        ray_cur;
      logic [D_W-1:0] delta, diff;
      logic           take;

      if (j == 0) begin : g_first
         assign rem_cur  = s_in;
         assign root_cur = '0;
         assign ray_cur  = ray_in;
      end else begin : g_next
         assign rem_cur  = rem_ff[j-1];
         assign root_cur = root_ff[j-1];
         assign ray_cur  = ray_ff[j-1];
      end

      // (q + 2^bit)^2 - q^2 = q * 2^(bit+1) + 2^(2*bit)
      always_comb begin
         delta = (D_W'(root_cur) << (BIT + 1)) + (D_W'(1) << (2 * BIT));
         diff  = D_W'(rem_cur) - delta;
         take  = !diff[D_W-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[j] <= root_cur | (R_W'(take) << BIT);
            ray_ff[j]  <= ray_cur;
         end
      end

      if (j < R_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j] <= take ? diff[S_W-1:0] : rem_cur;
            end
         end
      end
   end

   assign out_valid = v_ff[R_W-1];
   assign ray_out   = ray_ff[R_W-1];
   assign q_out     = root_ff[R_W-1];

endmodule

`default_nettype wire

// ----- sv/rsi_div.sv -----
// Pipelined floor divider for one axis: o + floor(+/-num / a), saturated to
// the coordinate range, one quotient bit per stage. Depends on rsi_pkg.
`default_nettype none

module rsi_div (
   input  logic                     clock,
   input  logic                     adv,
   input  logic [rsi_pkg::N_W-1:0]  num,
   input  logic                     neg,
   input  logic [rsi_pkg::A_W-1:0]  a,
   input  logic [rsi_pkg::CW-1:0]   org,
   output logic [rsi_pkg::CW-1:0]   pt
);
   import rsi_pkg::*;

   localparam int V_W = Q_W + 3;

   logic [N_W-1:0] rem_ff [Q_W+1];
   logic [Q_W-1:0] quo_ff [Q_W+1];
   logic           ovf_ff [Q_W+1];
   logic           neg_ff [Q_W+1];
   logic [CW-1:0]  org_ff [Q_W+1];
   logic [A_W-1:0] a_ff   [Q_W];
   logic [CW-1:0]  pt_ff;

   // stage 0: flag quotients that cannot fit, whatever the origin
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= num;
         quo_ff[0] <= '0;
         ovf_ff[0] <= num >= (N_W'(a) << Q_W);
         neg_ff[0] <= neg;
         org_ff[0] <= org;
         a_ff[0]   <= a;
      end
   end

   for (genvar j = 1; j <= Q_W; j++) begin : g_stage
      localparam int BIT = Q_W - j;
      logic [N_W-1:0] cand;
      logic           take;

      always_comb begin
         cand = N_W'(a_ff[j-1]) << BIT;
         take = rem_ff[j-1] >= cand;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= take ? rem_ff[j-1] - cand : rem_ff[j-1];
            quo_ff[j] <= quo_ff[j-1] | (Q_W'(take) << BIT);
            ovf_ff[j] <= ovf_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            org_ff[j] <= org_ff[j-1];
         end
      end

      if (j < Q_W) begin : g_a
         always_ff @(posedge clock) begin
            if (adv) begin
               a_ff[j] <= a_ff[j-1];
            end
         end
      end
   end

   // final stage: round toward minus infinity, add origin, saturate
   logic [Q_W:0]   mag;
   logic [V_W-1:0] val, sum, pmax, pmin;
   logic [CW-1:0]  pt_in;

   always_comb begin
      mag  = {1'b0, quo_ff[Q_W]} + (Q_W+1)'(neg_ff[Q_W] && (rem_ff[Q_W] != '0));
      val  = neg_ff[Q_W] ? -V_W'(mag) : V_W'(mag);
      sum  = val + V_W'($signed(org_ff[Q_W]));
      pmax = V_W'({1'b0, {(CW-1){1'b1}}});
      pmin = -V_W'({1'b1, {(CW-1){1'b0}}});
      if (ovf_ff[Q_W]) begin
         pt_in = neg_ff[Q_W] ? pmin[CW-1:0] : pmax[CW-1:0];
      end else if ($signed(sum) > $signed(pmax)) begin
         pt_in = pmax[CW-1:0];
      end else if ($signed(sum) < $signed(pmin)) begin
         pt_in = pmin[CW-1:0];
      end else begin
         pt_in = sum[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff <= pt_in;
      end
   end

   assign pt = pt_ff;

endmodule

`default_nettype wire

// ----- sv/ray_sphere_intersection.sv -----
// Ray/sphere intersection, fully pipelined. From input accept to result valid
// an item passes 6 front stages, 65 square-root stages, 3 scaling
// stages, 35 divider stages and the result register.
// Throughput is one item per cycle; the whole pipeline holds while a result
// waits. Reset clears all valid bits; data registers are not reset.
// Depends on rsi_pkg, rsi_front, rsi_sqrt and rsi_div.
`default_nettype none

module ray_sphere_intersection (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // center_x, center_y, center_z, radius, zero pad
   input  logic [rsi_pkg::IN_DW-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // entry_x, entry_y, entry_z, exit_x, exit_y, exit_z
   output logic [rsi_pkg::OUT_DW-1:0]    rsp_tdata,
   // hit
   output logic                          rsp_tuser
);
   import rsi_pkg::*;

   logic     adv;
   vec3_type origin, dir, center;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         origin[i] = req_tdata[i*CW +: CW];
         dir[i]    = req_tdata[(3+i)*CW +: CW];
         center[i] = req_tdata[(6+i)*CW +: CW];
      end
   end

   logic           fr_v;
   ray_type        fr_ray;
   logic [S_W-1:0] fr_s;

   rsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .origin    (origin),
      .dir       (dir),
      .center    (center),
      .radius    (req_tdata[9*CW +: CW-1]),
      .out_valid (fr_v),
      .ray_out   (fr_ray),
      .s_out     (fr_s)
   );

   logic           sq_v;
   ray_type        sq_ray;
   logic [R_W-1:0] sq_q;

   rsi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_v),
      .ray_in    (fr_ray),
      .s_in      (fr_s),
      .out_valid (sq_v),
      .ray_out   (sq_ray),
      .q_out     (sq_q)
   );

   // scale stage 1: near and far numerators, |d|
   logic                 t1_v_ff, t1_hit_ff;
   logic [A_W-1:0]       t1_a_ff;
   vec3_type             t1_o_ff, t1_dm_ff, t1_dm_in;
   logic [2:0]           t1_dn_ff;
   logic [T_W-1:0]       tn_ff, tf_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t1_dm_in[i] = sq_ray.d[i][CW-1] ? -sq_ray.d[i] : sq_ray.d[i];
      end
   end

   // scale stage 2: split products t*|d|
   logic                 t2_v_ff, t2_hit_ff;
   logic [A_W-1:0]       t2_a_ff;
   vec3_type             t2_o_ff;
   logic [2:0]           t2_dn_ff;
   logic [5:0][TP_W-1:0] t2_lo_ff, t2_hi_ff, t2_lo_in, t2_hi_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t2_lo_in[i]   = tn_ff[HALF-1:0] * t1_dm_ff[i];
         t2_hi_in[i]   = tn_ff[T_W-1:HALF] * t1_dm_ff[i];
         t2_lo_in[3+i] = tf_ff[HALF-1:0] * t1_dm_ff[i];
         t2_hi_in[3+i] = tf_ff[T_W-1:HALF] * t1_dm_ff[i];
      end
   end

   // scale stage 3: recombine into divider numerators
   logic                t3_v_ff, t3_hit_ff;
   logic [A_W-1:0]      t3_a_ff;
   vec3_type            t3_o_ff;
   logic [2:0]          t3_dn_ff;
   logic [5:0][N_W-1:0] t3_n_ff, t3_n_in;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         t3_n_in[k] = (N_W'(t2_hi_ff[k]) << HALF) + N_W'(t2_lo_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
         t2_v_ff <= 1'b0;
         t3_v_ff <= 1'b0;
      end else if (adv) begin
         t1_v_ff <= sq_v;
         t2_v_ff <= t1_v_ff;
         t3_v_ff <= t2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_hit_ff <= sq_ray.hit;
         t1_a_ff   <= sq_ray.a;
         t1_o_ff   <= sq_ray.o;
         t1_dm_ff  <= t1_dm_in;
         t1_dn_ff  <= {sq_ray.d[2][CW-1], sq_ray.d[1][CW-1], sq_ray.d[0][CW-1]};
         tn_ff     <= T_W'(sq_ray.b) - T_W'(sq_q);
         tf_ff     <= T_W'(sq_ray.b) + T_W'(sq_q);
         t2_hit_ff <= t1_hit_ff;
         t2_a_ff   <= t1_a_ff;
         t2_o_ff   <= t1_o_ff;
         t2_dn_ff  <= t1_dn_ff;
         t2_lo_ff  <= t2_lo_in;
         t2_hi_ff  <= t2_hi_in;
         t3_hit_ff <= t2_hit_ff;
         t3_a_ff   <= t2_a_ff;
         t3_o_ff   <= t2_o_ff;
         t3_dn_ff  <= t2_dn_ff;
         t3_n_ff   <= t3_n_in;
      end
   end

   // dividers: entry points then exit points
   logic [5:0][CW-1:0] pts;

   for (genvar k = 0; k < 6; k++) begin : g_div
      rsi_div u_div (
         .clock (clock),
         .adv   (adv),
         .num   (t3_n_ff[k]),
         .neg   (t3_dn_ff[k % 3]),
         .a     (t3_a_ff),
         .org   (t3_o_ff[k % 3]),
         .pt    (pts[k])
      );
   end

   logic [DIV_LAT-1:0] dv_ff, dh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (adv) begin
         dv_ff <= {dv_ff[DIV_LAT-2:0], t3_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dh_ff <= {dh_ff[DIV_LAT-2:0], t3_hit_ff};
      end
   end

   // result register; a miss drops the points to zero
   logic              rsp_valid_ff, rsp_hit_ff;
   logic [OUT_DW-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff  <= dh_ff[DIV_LAT-1];
         rsp_data_ff <= dh_ff[DIV_LAT-1] ? pts : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_ff) && $stable(t3_v_ff) && $stable(t1_v_ff))
      else $error("pipeline moved during a stall");

   a_miss_root_zero: assert property (@(posedge clock) disable iff (reset)
      sq_v && !sq_ray.hit |-> sq_q == '0)
      else $error("nonzero root for a missed ray");

   a_miss_zero_points: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss result carries nonzero points");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_ray_sphere_intersection.sv -----
// Self-checking testbench for ray_sphere_intersection: drives rays on the req_ stream,
// predicts each hit flag and intersection point with exact wide integer math, checks rsp_.
// Depends on rsi_pkg and the ray_sphere_intersection RTL.
`default_nettype none

module tb_ray_sphere_intersection;
   timeunit 1ns;
   timeprecision 1ps;
   import rsi_pkg::*;

   typedef logic signed [263:0] wide_type;

   typedef struct {
      logic                hit;
      logic [OUT_DW-1:0]   pts;
   } hit_result_type;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 130;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [IN_DW-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [OUT_DW-1:0]   rsp_tdata;
   logic                rsp_tuser;

   hit_result_type      expected_hits[$];
   int                  idle_pct = 0;
   int                  stall_pct = 0;
   int                  error_count = 0;
   int                  rays_sent = 0;
   int                  hits_seen = 0;
   int                  results_seen = 0;
   int                  cycle_count = 0;

   ray_sphere_intersection DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic wide_type floor_root(wide_type s);
      wide_type q, t;
      q = '0;
      for (int i = 65; i >= 0; i--) begin
         t = q | (wide_type'(1) << i);
         if (t * t <= s) q = t;
      end
      return q;
   endfunction

   function automatic logic [CW-1:0] clamp_coord(wide_type v);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (CW - 1)) - 1;
      lo = -(wide_type'(1) <<< (CW - 1));
      if (v > hi) return hi[CW-1:0];
      if (v < lo) return lo[CW-1:0];
      return v[CW-1:0];
   endfunction

   function automatic hit_result_type predict_intersection(logic [IN_DW-1:0] ray);
      hit_result_type res;
      wide_type o[3], d[3], p[3];
      wide_type a, b, k, s, r, q, tn, tf, num, quo;
      a = 0; b = 0; k = 0;
      for (int i = 0; i < 3; i++) begin
         o[i] = wide_type'($signed(ray[CW*i +: CW]));
         d[i] = wide_type'($signed(ray[CW*(3+i) +: CW]));
         p[i] = wide_type'($signed(ray[CW*(6+i) +: CW])) - o[i];
         a += d[i] * d[i];
         b += d[i] * p[i];
         k += p[i] * p[i];
      end
      r = wide_type'({1'b0, ray[CW*9 +: CW-1]});
      k -= r * r;
      s = b * b - a * k;
      res.hit = (a != 0) && (s >= 0) && (b >= 0) && (k >= 0);
      res.pts = '0;
      if (res.hit) begin
         q = floor_root(s);
         tn = b - q;
         tf = b + q;
         for (int i = 0; i < 6; i++) begin
            num = ((i < 3) ? tn : tf) * d[i % 3];
            quo = num / a;
            // round toward minus infinity
            if (num < 0 && quo * a != num) quo = quo - 1;
            res.pts[CW*i +: CW] = clamp_coord(quo + o[i % 3]);
         end
      end
      return res;
   endfunction

   task automatic send_ray(input logic [IN_DW-1:0] ray);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ray;
      do @(posedge clock); while (!req_tready);
      expected_hits.push_back(predict_intersection(ray));
      rays_sent++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [IN_DW-1:0] pack_ray(logic signed [CW-1:0] ox, oy, oz,
                                                 logic signed [CW-1:0] dx, dy, dz,
                                                 logic signed [CW-1:0] cx, cy, cz,
                                                 logic [CW-2:0] rad);
      return {1'b0, rad, cz, cy, cx, dz, dy, dx, oz, oy, ox};
   endfunction

   always @(posedge clock) begin
      hit_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_hits.size() == 0) begin
            $error("unexpected result item: hit=%0b data=%h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            exp_res = expected_hits.pop_front();
            if (rsp_tuser) hits_seen++;
            if (rsp_tuser !== exp_res.hit) begin
               $error("hit: expected %0b, actual %0b", exp_res.hit, rsp_tuser);
               error_count++;
            end
            for (int i = 0; i < 6; i++) begin
               if (rsp_tdata[CW*i +: CW] !== exp_res.pts[CW*i +: CW]) begin
                  $error("%s_%s: expected %h, actual %h", (i < 3) ? "entry" : "exit",
                         (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z",
                         exp_res.pts[CW*i +: CW], rsp_tdata[CW*i +: CW]);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic test_directed_cases();
      localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
      localparam logic signed [CW-1:0] MAXV = 32'sh7FFF_FFFF;
      localparam logic signed [CW-1:0] MINV = 32'sh8000_0000;
      // zero direction
      send_ray(pack_ray(0, 0, 0, 0, 0, 0, 10*ONE, 0, 0, (CW-1)'(ONE)));
      // straight through a sphere ahead
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 10*ONE, 0, 0, (CW-1)'(2*ONE)));
      // tangent ray: entry equals exit
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 10*ONE, ONE, 0, (CW-1)'(ONE)));
      // origin inside the sphere
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, ONE, 0, 0, (CW-1)'(4*ONE)));
      // sphere behind the ray
      send_ray(pack_ray(0, 0, 0, -ONE, 0, 0, 10*ONE, 0, 0, (CW-1)'(2*ONE)));
      // off to the side: negative discriminant
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 10*ONE, 20*ONE, 0, (CW-1)'(ONE)));
      // extremes of every field
      send_ray(pack_ray(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, '1));
      send_ray(pack_ray(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, '1));
      send_ray(pack_ray(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, '1));
      send_ray(pack_ray(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MINV, MINV, '1));
      send_ray(pack_ray(MINV, 0, 0, 1, 0, 0, MAXV, 0, 0, 0));
      send_ray(pack_ray(MINV, 0, 0, MAXV, 0, 0, MAXV, 0, 0, '1));
      // saturated points: tiny direction, huge sphere
      send_ray(pack_ray(0, 0, 0, 1, 1, 1, MAXV, MAXV, MAXV, '1));
      send_ray(pack_ray(0, 0, 0, -1, -1, -1, MINV, MINV, MINV, '1));
      send_ray(pack_ray(-5*ONE, 3*ONE, 0, 3, -7, 2, 0, 0, 0, 0));
      send_ray(pack_ray(0, 0, 0, 0, 0, 1, 0, 0, 5, 5));
      send_ray(pack_ray(0, 0, 0, 0, 0, -3, 0, 0, -9, 1));
      send_ray(pack_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_ray({IN_DW{1'b1}} >> 1);
   endtask

   function automatic logic signed [CW-1:0] rand_span(int bits);
      logic signed [CW-1:0] v;
      v = $urandom;
      return v >>> (CW - bits);
   endfunction

   task automatic test_random_rays(int count);
      logic signed [CW-1:0] o[3], d[3], c[3];
      logic [CW-2:0] rad;
      int mode, bits, m;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(99);
         if (mode < 55) begin
            // aimed ray: sphere placed along the direction, radius of random size
            m = $urandom_range(1, 64);
            bits = $urandom_range(4, 20);
            for (int i = 0; i < 3; i++) begin
               o[i] = rand_span(25);
               d[i] = rand_span(bits);
               c[i] = o[i] + d[i] * m + rand_span(bits);
            end
            rad = (CW-1)'($urandom_range(0, (1 << (bits + 3)) * m));
         end else if (mode < 80) begin
            for (int i = 0; i < 3; i++) begin
               o[i] = $urandom; d[i] = $urandom; c[i] = $urandom;
            end
            rad = (CW-1)'($urandom);
         end else begin
            bits = $urandom_range(1, 32);
            for (int i = 0; i < 3; i++) begin
               o[i] = rand_span(bits); d[i] = rand_span($urandom_range(1, 32));
               c[i] = rand_span(bits);
            end
            rad = (CW-1)'($urandom >> $urandom_range(1, 31));
         end
         send_ray(pack_ray(o[0], o[1], o[2], d[0], d[1], d[2], c[0], c[1], c[2], rad));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      idle_pct = 0;  stall_pct = 0;  test_random_rays(430);
      idle_pct = 70; stall_pct = 0;  test_random_rays(430);
      idle_pct = 0;  stall_pct = 70; test_random_rays(430);
      idle_pct = 37; stall_pct = 37; test_random_rays(430);
      stop_sending();
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d rays through four idle/stall mixes; %0d results checked, %0d hits.",
               rays_sent, results_seen, hits_seen);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
sv/rsi_pkg.sv
sv/rsi_front.sv
sv/rsi_sqrt.sv
sv/rsi_div.sv
sv/ray_sphere_intersection.sv
tb/tb_ray_sphere_intersection.sv
